FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/ifl_pkg.sv
// ----------------------------------------------------------------------------
// ifl_pkg
// Types, constants and helpers of the image fit layout block.
// ----------------------------------------------------------------------------
package ifl_pkg;

    localparam int unsigned C_MAX_DIM    = 32767;
    localparam int unsigned C_QUEUE_DEP  = 2;
    localparam int unsigned C_DIV_STEPS  = 4;
    localparam int unsigned C_DIV_CYCLES = 16 / C_DIV_STEPS;

    typedef enum logic [2:0] {
        CFG_BASE_X      = 3'd0,
        CFG_BASE_Y      = 3'd1,
        CFG_BASE_WIDTH  = 3'd2,
        CFG_BASE_HEIGHT = 3'd3,
        CFG_ROT_X       = 3'd4,
        CFG_ROT_Y       = 3'd5,
        CFG_ROT_WIDTH   = 3'd6,
        CFG_ROT_HEIGHT  = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_SET,
        S_DIV
    } t_back_state;

    typedef struct packed {
        logic [15:0] source_width;
        logic [15:0] source_height;
        logic [15:0] screen_width;
        logic [15:0] screen_height;
        logic [1:0]  orientation;
        logic        rotate_allowed;
        logic        is_bitmap;
    } t_in_req;

    typedef struct packed {
        logic        ok;
        logic [1:0]  out_orientation;
        logic [15:0] layout_screen_width;
        logic [15:0] layout_screen_height;
        logic [14:0] place_x;
        logic [14:0] place_y;
        logic [14:0] place_width;
        logic [14:0] place_height;
    } t_out_res;

    typedef struct packed {
        logic [15:0] base_x;
        logic [15:0] base_y;
        logic [15:0] base_width;
        logic [15:0] base_height;
        logic [15:0] rot_x;
        logic [15:0] rot_y;
        logic [15:0] rot_width;
        logic [15:0] rot_height;
    } t_cfg;

    typedef struct packed {
        logic        ok;
        logic        keep;
        logic [1:0]  ori;
        logic [15:0] scr_w;
        logic [15:0] scr_h;
        logic [14:0] sw;
        logic [14:0] sh;
        logic [14:0] vx;
        logic [14:0] vy;
        logic [14:0] vw;
        logic [14:0] vh;
    } t_job;

    function automatic logic dim_ok(input logic [15:0] v);
        return (v != 16'd0) && ({16'd0, v} <= 32'(C_MAX_DIM));
    endfunction

endpackage

FILE: hw/rtl/ifl_front.sv
// ----------------------------------------------------------------------------
// ifl_front
// Classifies a request (rotation, viewport, validity) and queues the job.
// ----------------------------------------------------------------------------
module ifl_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ifl_pkg::t_cfg  i_cfg,
    input  logic           i_push,
    input  ifl_pkg::t_in_req i_req,
    output logic           o_full,
    output logic           o_job_valid,
    output ifl_pkg::t_job  o_job,
    input  logic           i_job_pop
);
    import ifl_pkg::*;

    localparam int unsigned PW = $clog2(C_QUEUE_DEP);

    logic        rotate;
    logic [15:0] vx, vy, vw, vh;
    logic [16:0] ex, ey;
    logic        valid;
    t_job        job;

    t_job        r_mem [C_QUEUE_DEP];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [PW:0]   r_count;
    logic        wr_en, rd_en;

    always_comb begin
        rotate = i_req.rotate_allowed
            && dim_ok(i_req.source_width) && dim_ok(i_req.source_height)
            && dim_ok(i_req.screen_width) && dim_ok(i_req.screen_height)
            && (i_req.source_width != i_req.source_height)
            && (i_req.screen_width != i_req.screen_height)
            && ((i_req.source_width > i_req.source_height)
                != (i_req.screen_width > i_req.screen_height));
        vx = rotate ? i_cfg.rot_x      : i_cfg.base_x;
        vy = rotate ? i_cfg.rot_y      : i_cfg.base_y;
        vw = rotate ? i_cfg.rot_width  : i_cfg.base_width;
        vh = rotate ? i_cfg.rot_height : i_cfg.base_height;
        ex = {1'b0, vx} + {1'b0, vw};
        ey = {1'b0, vy} + {1'b0, vh};
        valid = dim_ok(i_req.source_width) && dim_ok(i_req.source_height)
            && dim_ok(vw) && dim_ok(vh)
            && ({16'd0, vx} <= 32'(C_MAX_DIM)) && ({16'd0, vy} <= 32'(C_MAX_DIM))
            && ({15'd0, ex} <= 32'(C_MAX_DIM)) && ({15'd0, ey} <= 32'(C_MAX_DIM));
        job.ok    = valid;
        job.keep  = i_req.is_bitmap && (i_req.source_width <= vw)
            && (i_req.source_height <= vh);
        job.ori   = rotate ? i_req.orientation + 2'd3 : i_req.orientation;
        job.scr_w = rotate ? i_req.screen_height : i_req.screen_width;
        job.scr_h = rotate ? i_req.screen_width  : i_req.screen_height;
        job.sw    = i_req.source_width[14:0];
        job.sh    = i_req.source_height[14:0];
        job.vx    = vx[14:0];
        job.vy    = vy[14:0];
        job.vw    = vw[14:0];
        job.vh    = vh[14:0];
    end

    assign o_full      = (r_count == (PW+1)'(C_QUEUE_DEP));
    assign o_job_valid = (r_count != '0);
    assign o_job       = r_mem[r_rd_ptr];
    assign wr_en       = i_push && !o_full;
    assign rd_en       = i_job_pop && o_job_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= job;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (PW+1)'(wr_en) - (PW+1)'(rd_en);
        end
    end

endmodule

FILE: hw/rtl/ifl_back.sv
// ----------------------------------------------------------------------------
// ifl_back
// Scales, clamps and centers one queued job and holds the result.
// ----------------------------------------------------------------------------
module ifl_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  ifl_pkg::t_job    i_job,
    output logic             o_job_pop,
    input  logic             pop,
    output logic             empty,
    output ifl_pkg::t_out_res o_res
);
    import ifl_pkg::*;

    localparam int unsigned CW = $clog2(C_DIV_CYCLES + 1);

    t_back_state r_state, n_state;
    t_job        r_job;
    logic [29:0] r_a, r_b;
    logic        r_wide;
    logic [14:0] r_den, r_rem;
    logic [15:0] r_quo;
    logic [CW-1:0] r_cnt;
    t_out_res    r_out;
    logic        r_out_valid;

    logic        fin, out_free, take, wide;
    logic [30:0] num;
    logic [14:0] rem_n;
    logic [15:0] quo_n, t;
    logic [15:0] fw, fh;
    logic [14:0] fw_c, fh_c;
    t_out_res    res;

    assign out_free = !r_out_valid || pop;
    assign wide     = (r_a > r_b);
    assign fin      = (r_state == S_DIV) && (r_cnt == CW'(C_DIV_CYCLES)) && out_free;

    always_comb begin
        n_state = r_state;
        take    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    take    = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: n_state = S_SET;
            S_SET: n_state = S_DIV;
            S_DIV: begin
                if (fin) begin
                    take    = i_job_valid;
                    n_state = i_job_valid ? S_MUL : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
    assign o_job_pop = take;

    always_comb begin
        num   = wide ? {1'b0, r_b} + 31'(r_job.sw >> 1)
                     : {1'b0, r_a} + 31'(r_job.sh >> 1);
        rem_n = r_rem;
        quo_n = r_quo;
        t     = '0;
        for (int i = 0; i < C_DIV_STEPS; i++) begin
            t = {rem_n, quo_n[15]};
            quo_n = {quo_n[14:0], (t >= {1'b0, r_den})};
            rem_n = (t >= {1'b0, r_den}) ? 15'(t - {1'b0, r_den}) : t[14:0];
        end
    end

    always_comb begin
        if (r_job.keep) begin
            fw = {1'b0, r_job.sw};
            fh = {1'b0, r_job.sh};
        end else if (r_wide) begin
            fw = {1'b0, r_job.vw};
            fh = r_quo;
        end else begin
            fw = r_quo;
            fh = {1'b0, r_job.vh};
        end
        if (fw == '0) fw = 16'd1;
        if (fh == '0) fh = 16'd1;
        fw_c = (fw > {1'b0, r_job.vw}) ? r_job.vw : fw[14:0];
        fh_c = (fh > {1'b0, r_job.vh}) ? r_job.vh : fh[14:0];
        res.ok                   = r_job.ok;
        res.out_orientation      = r_job.ori;
        res.layout_screen_width  = r_job.scr_w;
        res.layout_screen_height = r_job.scr_h;
        res.place_x      = r_job.ok ? r_job.vx + ((r_job.vw - fw_c) >> 1) : '0;
        res.place_y      = r_job.ok ? r_job.vy + ((r_job.vh - fh_c) >> 1) : '0;
        res.place_width  = r_job.ok ? fw_c : '0;
        res.place_height = r_job.ok ? fh_c : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job <= i_job;
        end
        unique case (r_state)
            S_MUL: begin
                r_a <= 30'(r_job.sw) * 30'(r_job.vh);
                r_b <= 30'(r_job.vw) * 30'(r_job.sh);
            end
            S_SET: begin
                r_wide <= wide;
                r_den  <= wide ? r_job.sw : r_job.sh;
                r_rem  <= num[30:16];
                r_quo  <= num[15:0];
                r_cnt  <= '0;
            end
            S_DIV: begin
                if (r_cnt != CW'(C_DIV_CYCLES)) begin
                    r_rem <= rem_n;
                    r_quo <= quo_n;
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            default: ;
        endcase
        if (fin) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign empty = !r_out_valid;
    assign o_res = r_out;

endmodule

FILE: hw/rtl/image_fit_layout.sv
// ----------------------------------------------------------------------------
// image_fit_layout
// Fits an image into a configured viewport, rotating it when that suits.
// ----------------------------------------------------------------------------
// Requests enter through push/full: one is taken at a clock edge with push
// high and full low. Results leave through empty/pop: the oldest result sits
// on o_res while empty is low and is taken at an edge with pop high.
// Viewport registers are written through i_cfg_valid/o_cfg_ready with a
// register index and 16-bit data; write them only while the block is idle.
// A request occupies the back end through multiply, setup, the steps of a
// 4-bit-per-cycle divider and finish; the next is taken only at the finish
// step, and a 2-entry queue lets further requests arrive in the meantime.
// Reset (synchronous, active low) empties queue and result register and
// clears all viewport registers. When pop stays low the result is held,
// the back end stops at its finish step and full rises once the queue fills.
// ----------------------------------------------------------------------------
module image_fit_layout (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  ifl_pkg::t_in_req  i_req,
    output logic              empty,
    input  logic              pop,
    output ifl_pkg::t_out_res o_res,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);
    import ifl_pkg::*;

    t_cfg  r_cfg;
    t_job  job;
    logic  job_valid, job_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BASE_X:      r_cfg.base_x      <= i_cfg_data;
                CFG_BASE_Y:      r_cfg.base_y      <= i_cfg_data;
                CFG_BASE_WIDTH:  r_cfg.base_width  <= i_cfg_data;
                CFG_BASE_HEIGHT: r_cfg.base_height <= i_cfg_data;
                CFG_ROT_X:       r_cfg.rot_x       <= i_cfg_data;
                CFG_ROT_Y:       r_cfg.rot_y       <= i_cfg_data;
                CFG_ROT_WIDTH:   r_cfg.rot_width   <= i_cfg_data;
                CFG_ROT_HEIGHT:  r_cfg.rot_height  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ifl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_push      (push),
        .i_req       (i_req),
        .o_full      (full),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    ifl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .pop         (pop),
        .empty       (empty),
        .o_res       (o_res)
    );

endmodule

FILE: hw/rtl/ifl_checker.sv
// ----------------------------------------------------------------------------
// ifl_checker
// Port-level checks of the image fit layout block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ifl_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              push,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input ifl_pkg::t_out_res o_res,
    input logic              o_cfg_ready
);
    import ifl_pkg::*;

    `ASSERT_CLK(a_reset_empty, i_clk, 1'b1, !i_rst_n |=> empty && !full, "not empty after reset")
    `ASSERT_CLK(a_hold_result, i_clk, i_rst_n, !empty && !pop |=> !empty && $stable(o_res), "result changed while stalled")
    `ASSERT_CLK(a_fail_zero, i_clk, i_rst_n, !empty && !o_res.ok |-> o_res.place_width == '0 && o_res.place_height == '0 && o_res.place_x == '0 && o_res.place_y == '0, "failed result not zeroed")
    `ASSERT_CLK(a_ok_size, i_clk, i_rst_n, !empty && o_res.ok |-> o_res.place_width != '0 && o_res.place_height != '0, "fitted size zero")
    `ASSERT_ALWAYS(a_cfg_ready, i_clk, o_cfg_ready, "config port not ready")

endmodule

bind image_fit_layout ifl_checker u_ifl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .push        (push),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_res       (o_res),
    .o_cfg_ready (o_cfg_ready)
);

FILE: verif/tb_image_fit_layout.sv
// ----------------------------------------------------------------------------
// tb_image_fit_layout
// Self-checking bench for the image fit layout block.
// ----------------------------------------------------------------------------
// Drives layout requests through the push/full side and takes placements from
// the empty/pop side, both with random idling. A scoreboard class predicts
// each placement from the request and its own copy of the viewport registers
// and checks every popped result in order. Registers are rewritten between
// phases while the block is idle, covering extremes and invalid viewports.
// ----------------------------------------------------------------------------
module tb_image_fit_layout;
    import ifl_pkg::*;

    localparam int unsigned MAX_DIM = 32767;

    class layout_scoreboard;
        t_cfg       regs;
        t_out_res   pending[$];
        int         mismatches;

        function void clear_regs();
            regs = '0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [15:0] data);
            case (idx)
                CFG_BASE_X:      regs.base_x = data;
                CFG_BASE_Y:      regs.base_y = data;
                CFG_BASE_WIDTH:  regs.base_width = data;
                CFG_BASE_HEIGHT: regs.base_height = data;
                CFG_ROT_X:       regs.rot_x = data;
                CFG_ROT_Y:       regs.rot_y = data;
                CFG_ROT_WIDTH:   regs.rot_width = data;
                CFG_ROT_HEIGHT:  regs.rot_height = data;
            endcase
        endfunction

        function bit size_valid(logic [15:0] v);
            return v != 0 && v <= MAX_DIM;
        endfunction

        function longint unsigned div_round(longint unsigned v, longint unsigned num,
                                            longint unsigned den);
            return (v * num + den / 2) / den;
        endfunction

        function void note_request(t_in_req r);
            t_out_res        res;
            bit              turn;
            longint unsigned vx, vy, vw, vh, fw, fh, a, b;
            turn = 0;
            res = '0;
            if (r.rotate_allowed && size_valid(r.source_width) && size_valid(r.source_height)
                && size_valid(r.screen_width) && size_valid(r.screen_height)
                && r.source_width != r.source_height && r.screen_width != r.screen_height)
                turn = (r.source_width > r.source_height) != (r.screen_width > r.screen_height);
            res.out_orientation = turn ? r.orientation + 2'd3 : r.orientation;
            res.layout_screen_width  = turn ? r.screen_height : r.screen_width;
            res.layout_screen_height = turn ? r.screen_width : r.screen_height;
            vx = turn ? regs.rot_x : regs.base_x;
            vy = turn ? regs.rot_y : regs.base_y;
            vw = turn ? regs.rot_width : regs.base_width;
            vh = turn ? regs.rot_height : regs.base_height;
            if (size_valid(r.source_width) && size_valid(r.source_height)
                && size_valid(vw) && size_valid(vh) && vx <= MAX_DIM && vy <= MAX_DIM
                && vx + vw <= MAX_DIM && vy + vh <= MAX_DIM) begin
                fw = r.source_width;
                fh = r.source_height;
                if (!r.is_bitmap || fw > vw || fh > vh) begin
                    a = fw * vh;
                    b = vw * fh;
                    if (a > b) begin
                        fh = div_round(r.source_height, vw, r.source_width);
                        fw = vw;
                    end else begin
                        fw = div_round(r.source_width, vh, r.source_height);
                        fh = vh;
                    end
                end
                if (fw < 1) fw = 1;
                if (fh < 1) fh = 1;
                if (fw > vw) fw = vw;
                if (fh > vh) fh = vh;
                res.ok = 1'b1;
                res.place_x = 15'(vx + (vw - fw) / 2);
                res.place_y = 15'(vy + (vh - fh) / 2);
                res.place_width = 15'(fw);
                res.place_height = 15'(fh);
            end
            pending.push_back(res);
        endfunction

        function void check_result(t_out_res got);
            t_out_res want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected ok=%0d ori=%0d scr=%0d/%0d ",
                              "place=%0d,%0d %0dx%0d, got ok=%0d ori=%0d ",
                              "scr=%0d/%0d place=%0d,%0d %0dx%0d"},
                        want.ok, want.out_orientation, want.layout_screen_width,
                        want.layout_screen_height, want.place_x, want.place_y,
                        want.place_width, want.place_height,
                        got.ok, got.out_orientation, got.layout_screen_width,
                        got.layout_screen_height, got.place_x, got.place_y,
                        got.place_width, got.place_height);
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    t_in_req    i_req = '0;
    logic       empty;
    logic       pop = 1'b0;
    t_out_res   o_res;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    layout_scoreboard sb = new();
    bit   calm = 1'b0;
    bit   hold_off = 1'b0;

    image_fit_layout uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_req(i_req),
        .empty(empty), .pop(pop), .o_res(o_res),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && push && !full)
            sb.note_request(i_req);
        if (i_rst_n && pop && !empty)
            sb.check_result(o_res);
        if (!i_rst_n || hold_off)
            pop <= 1'b0;
        else
            pop <= calm || ($urandom_range(99) >= 11);
    end

    task automatic write_reg(t_cfg_idx idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic load_viewports(logic [15:0] bx, by, bw, bh, rx, ry, rw, rh);
        write_reg(CFG_BASE_X, bx);
        write_reg(CFG_BASE_Y, by);
        write_reg(CFG_BASE_WIDTH, bw);
        write_reg(CFG_BASE_HEIGHT, bh);
        write_reg(CFG_ROT_X, rx);
        write_reg(CFG_ROT_Y, ry);
        write_reg(CFG_ROT_WIDTH, rw);
        write_reg(CFG_ROT_HEIGHT, rh);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_request(t_in_req r);
        while (!calm && $urandom_range(99) < 11) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push  <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (full);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        push <= 1'b0;
        while (sb.pending.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_dim(bit wide);
        case ($urandom_range(9))
            0: return 16'($urandom_range(65535));
            1: return 16'($urandom_range(2));
            2: return 16'(MAX_DIM - $urandom_range(1));
            3: return 16'(MAX_DIM + 1);
            default: return wide ? 16'($urandom_range(1, 4000)) : 16'($urandom_range(1, 300));
        endcase
    endfunction

    function automatic t_in_req make_request(logic [15:0] w, h, cw, ch, logic [1:0] o,
                                             logic ra, logic bm);
        t_in_req r;
        r.source_width = w;
        r.source_height = h;
        r.screen_width = cw;
        r.screen_height = ch;
        r.orientation = o;
        r.rotate_allowed = ra;
        r.is_bitmap = bm;
        return r;
    endfunction

    function automatic t_in_req random_request();
        t_in_req r;
        if ($urandom_range(9) < 2) begin
            r = t_in_req'($bits(t_in_req)'({$urandom, $urandom, $urandom}));
        end else begin
            r = make_request(pick_dim(1), pick_dim(1), pick_dim(1), pick_dim(1),
                             2'($urandom_range(3)), 1'($urandom_range(1)),
                             1'($urandom_range(1)));
        end
        return r;
    endfunction

    initial begin
        #200000000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        sb.clear_regs();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_viewports(16'd10, 16'd20, 16'd800, 16'd600, 16'd5, 16'd7, 16'd600, 16'd800);
        send_request(make_request(16'd1, 16'd1, 16'd1, 16'd1, 2'd0, 1'b1, 1'b0));
        send_request(make_request(16'd400, 16'd300, 16'd600, 16'd800, 2'd1, 1'b1, 1'b0));
        send_request(make_request(16'd400, 16'd300, 16'd600, 16'd800, 2'd0, 1'b1, 1'b1));
        send_request(make_request(16'd400, 16'd300, 16'd600, 16'd800, 2'd3, 1'b0, 1'b0));
        send_request(make_request(16'd300, 16'd300, 16'd600, 16'd800, 2'd2, 1'b1, 1'b0));
        send_request(make_request(16'd400, 16'd300, 16'd800, 16'd800, 2'd2, 1'b1, 1'b0));
        send_request(make_request(16'd0, 16'd300, 16'd600, 16'd800, 2'd1, 1'b1, 1'b0));
        send_request(make_request(16'd400, 16'd0, 16'd600, 16'd800, 2'd1, 1'b1, 1'b0));
        send_request(make_request(16'd32768, 16'd300, 16'd600, 16'd800, 2'd1, 1'b1, 1'b0));
        send_request(make_request(16'd400, 16'd300, 16'd0, 16'd800, 2'd1, 1'b1, 1'b0));
        send_request(make_request(16'd400, 16'd300, 16'd600, 16'hFFFF, 2'd1, 1'b1, 1'b0));
        send_request(make_request(16'd32767, 16'd1, 16'd1, 16'd32767, 2'd3, 1'b1, 1'b1));
        send_request(make_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3, 1'b1, 1'b1));
        send_request(make_request(16'd5, 16'd3, 16'd7, 16'd9, 2'd2, 1'b1, 1'b1));
        send_request(make_request(16'd2000, 16'd1, 16'd7, 16'd9, 2'd0, 1'b0, 1'b1));
        drain();

        load_viewports(16'd32767, 16'd0, 16'd1, 16'd1, 16'd0, 16'd32767, 16'd32767, 16'd1);
        send_request(make_request(16'd400, 16'd300, 16'd600, 16'd800, 2'd1, 1'b1, 1'b0));
        send_request(make_request(16'd400, 16'd300, 16'd800, 16'd600, 2'd1, 1'b1, 1'b0));
        drain();
        load_viewports(16'd0, 16'd0, 16'd32767, 16'd32767, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
        send_request(make_request(16'd1, 16'd32767, 16'd800, 16'd600, 2'd1, 1'b1, 1'b0));
        send_request(make_request(16'd32767, 16'd1, 16'd600, 16'd800, 2'd0, 1'b0, 1'b0));
        send_request(make_request(16'd1, 16'd2, 16'd600, 16'd800, 2'd0, 1'b0, 1'b1));
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: load_viewports(16'd0, 16'd0, 16'd1024, 16'd768, 16'd0, 16'd0, 16'd768, 16'd1024);
                1: load_viewports(16'd100, 16'd50, 16'd37, 16'd211, 16'd3, 16'd9, 16'd250, 16'd17);
                2: load_viewports(16'd16383, 16'd16383, 16'd16384, 16'd16384,
                                  16'd16384, 16'd1, 16'd16384, 16'd32766);
                default: load_viewports(16'($urandom_range(2000)), 16'($urandom_range(2000)),
                                        pick_dim(1), pick_dim(1),
                                        16'($urandom_range(2000)), 16'($urandom_range(2000)),
                                        pick_dim(1), pick_dim(1));
            endcase
            calm = (phase == 2);
            if (phase == 1) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (150) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < 205; n++)
                send_request(random_request());
            calm = 1'b0;
            drain();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/ifl_pkg.sv
hw/rtl/ifl_front.sv
hw/rtl/ifl_back.sv
hw/rtl/image_fit_layout.sv
hw/rtl/ifl_checker.sv
verif/tb_image_fit_layout.sv
